// File: sv/mrs_pkg.sv
// Shared types and constants of the Modbus RTU slave engine.
package mrs_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 256;
  localparam int unsigned REG_DEPTH_DEF = 64;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT = 1'd1;
  localparam logic [7:0] SLAVE_ADDRESS_RST = 8'd1;
  localparam logic [6:0] REGISTER_COUNT_RST = 7'd64;

  localparam logic [2:0] KIND_RX_BYTE = 3'd0;
  localparam logic [2:0] KIND_SILENCE = 3'd1;
  localparam logic [2:0] KIND_TX_READY = 3'd2;
  localparam logic [2:0] KIND_TX_DONE = 3'd3;
  localparam logic [2:0] KIND_HOST_WRITE = 3'd4;
  localparam logic [2:0] KIND_HOST_READ = 3'd5;

  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;
  localparam logic [7:0] EXC_FLAG = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS = 8'd2;
  localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'd3;
  localparam logic [7:0] BROADCAST_ADDRESS = 8'd0;

  localparam int unsigned MIN_FRAME = 4;
  localparam int unsigned HDR_BYTES = 7;
  localparam int unsigned READ_REQ_LEN = 8;
  localparam int unsigned WRITE_MIN_LEN = 10;
  localparam int unsigned WRITE_HDR_LEN = 9;
  localparam int unsigned WRITE_DATA_OFS = 7;
  localparam int unsigned SHORT_RSP_LEN = 3;
  localparam int unsigned READ_RSP_OVERHEAD = 5;
  localparam int unsigned WRITE_RSP_LEN = 6;
  localparam int unsigned FC_POS = 1;
  localparam int unsigned EXC_POS = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RECEIVE = 3'd1,
    PH_PARSE = 3'd2,
    PH_SEND = 3'd3,
    PH_SENT = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_CRC,
    S_CHECK,
    S_EXC1,
    S_EXC2,
    S_R3_HDR,
    S_R3_LOOP,
    S_R3_WH,
    S_R3_WL,
    S_W_LOOP,
    S_W_HI,
    S_W_LO,
    S_TAIL1,
    S_TAIL2
  } seq_t;

endpackage

// File: sv/modbus_rtu_slave_engine_top.sv
// Top level of the Modbus RTU slave engine: event sequencer and frame buffer.
//
// Usage: an event (kind, rx_byte, gap_late, host_index, host_value) is
// transferred at a rising edge where start is high and busy is low. Busy
// then stays high until the event is handled, and exactly one result
// appears on tx_valid, tx_byte, drive_transmit, request_done,
// host_read_data and link_state for one cycle, marked by result_valid.
// The receiver cannot stall; each result must be taken in its cycle.
// Configuration writes use cfg_write, cfg_index and cfg_data; the user must
// issue them only while idle, as the block does not enforce this. Received
// bytes, transmitter events and host accesses pass through S_FETCH, for the
// frame buffer or register file read, and S_EXEC, to update state, before
// the result is registered. A silence event walks the frame through the
// shared CRC unit one byte per cycle, copies registers for function 3 or
// function 16, then runs the CRC over the response. Reset returns the
// link to idle and clears both register files through their valid bits;
// the frame buffer is not cleared.
module modbus_rtu_slave_engine_top
  import mrs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int unsigned REG_DEPTH = REG_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            kind,
  input  logic [7:0]            rx_byte,
  input  logic                  gap_late,
  input  logic [5:0]            host_index,
  input  logic [15:0]           host_value,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  output logic                  tx_valid,
  output logic [7:0]            tx_byte,
  output logic                  drive_transmit,
  output logic                  request_done,
  output logic [15:0]           host_read_data,
  output logic [2:0]            link_state
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned IW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned RW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;

  logic [7:0] slave_address;
  logic [6:0] register_count;

  logic [2:0]  in_kind;
  logic [7:0]  in_rx_byte;
  logic        in_gap_late;
  logic [5:0]  in_host_index;
  logic [15:0] in_host_value;

  seq_t   state, state_next;
  phase_t phase, phase_next;
  logic [IW-1:0] byte_index, byte_index_next;
  logic          frame_error, frame_error_next;
  logic [IW-1:0] response_last, response_last_next;
  logic [IW-1:0] cnt, cnt_next;
  logic [IW-1:0] len, len_next;
  logic [IW-1:0] rd_pos, rd_pos_next;
  logic          rd_v, rd_v_next;
  logic          pass2, pass2_next;
  logic [6:0]    idx, idx_next;
  logic [6:0]    qty_r, qty_r_next;
  logic [6:0]    first_r, first_r_next;
  logic [IW-1:0] wptr, wptr_next;
  logic [7:0]    excode, excode_next;
  logic [7:0]    hi_byte, hi_byte_next;
  logic [7:0]    hdr [HDR_BYTES];

  logic          accept;
  logic          fin, fin_tx, fin_done;
  logic [7:0]    fin_txb;
  logic [15:0]   fin_hread;

  logic [7:0]    fb_mem [FRAME_BYTES];
  logic          fb_we;
  logic [AW-1:0] fb_waddr, fb_raddr;
  logic [7:0]    fb_wdata, fb_rdata;

  logic          crc_clear, crc_feed;
  logic [15:0]   crc;

  logic          rreg_we, rreg_re, wreg_we, wreg_re;
  logic [RW-1:0] rreg_raddr, wreg_waddr;
  logic [15:0]   rreg_rdata, wreg_wdata, wreg_rdata;

  logic [6:0]    count7;
  logic [15:0]   first16, qty16;
  logic          range_bad, host_in_range;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  assign count7 = (register_count > 7'(REG_DEPTH)) ? 7'(REG_DEPTH) : register_count;
  assign first16 = {hdr[2], hdr[3]};
  assign qty16 = {hdr[4], hdr[5]};
  assign range_bad = (first16 >= 16'(count7)) ||
                     ((17'(first16) + 17'(qty16)) > 17'(count7));
  assign host_in_range = (32'(in_host_index) < REG_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RST;
      register_count <= REGISTER_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS:  slave_address <= cfg_data;
        CFG_REGISTER_COUNT: register_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind <= kind;
      in_rx_byte <= rx_byte;
      in_gap_late <= gap_late;
      in_host_index <= host_index;
      in_host_value <= host_value;
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    fb_rdata <= fb_mem[fb_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_CRC && rd_v && !pass2 && rd_pos < IW'(HDR_BYTES)) begin
      hdr[rd_pos[2:0]] <= fb_rdata;
    end
  end

  mrs_crc u_crc (
    .clk   (clk),
    .clear (crc_clear),
    .feed  (crc_feed),
    .data  (fb_rdata),
    .crc   (crc)
  );

  mrs_regfile #(.DEPTH(REG_DEPTH), .AWID(RW)) u_readable (
    .clk   (clk),
    .rst   (rst),
    .we    (rreg_we),
    .waddr (RW'(in_host_index)),
    .wdata (in_host_value),
    .re    (rreg_re),
    .raddr (rreg_raddr),
    .rdata (rreg_rdata)
  );

  mrs_regfile #(.DEPTH(REG_DEPTH), .AWID(RW)) u_written (
    .clk   (clk),
    .rst   (rst),
    .we    (wreg_we),
    .waddr (wreg_waddr),
    .wdata (wreg_wdata),
    .re    (wreg_re),
    .raddr (RW'(in_host_index)),
    .rdata (wreg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
      byte_index <= '0;
      frame_error <= 1'b0;
      response_last <= '0;
      rd_v <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      byte_index <= byte_index_next;
      frame_error <= frame_error_next;
      response_last <= response_last_next;
      rd_v <= rd_v_next;
      result_valid <= fin;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    len <= len_next;
    rd_pos <= rd_pos_next;
    pass2 <= pass2_next;
    idx <= idx_next;
    qty_r <= qty_r_next;
    first_r <= first_r_next;
    wptr <= wptr_next;
    excode <= excode_next;
    hi_byte <= hi_byte_next;
    if (fin) begin
      tx_valid <= fin_tx;
      tx_byte <= fin_tx ? fin_txb : 8'h00;
      request_done <= fin_done;
      host_read_data <= fin_hread;
      link_state <= phase_next;
      drive_transmit <= (phase_next == PH_SEND) || (phase_next == PH_SENT);
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    byte_index_next = byte_index;
    frame_error_next = frame_error;
    response_last_next = response_last;
    cnt_next = cnt;
    len_next = len;
    rd_pos_next = rd_pos;
    rd_v_next = 1'b0;
    pass2_next = pass2;
    idx_next = idx;
    qty_r_next = qty_r;
    first_r_next = first_r;
    wptr_next = wptr;
    excode_next = excode;
    hi_byte_next = hi_byte;
    fin = 1'b0;
    fin_tx = 1'b0;
    fin_txb = 8'h00;
    fin_done = 1'b0;
    fin_hread = 16'h0000;
    fb_we = 1'b0;
    fb_waddr = '0;
    fb_wdata = 8'h00;
    fb_raddr = byte_index[AW-1:0];
    crc_clear = 1'b0;
    crc_feed = 1'b0;
    rreg_we = 1'b0;
    rreg_re = 1'b0;
    rreg_raddr = RW'(7'(first_r + idx));
    wreg_we = 1'b0;
    wreg_re = 1'b0;
    wreg_waddr = RW'(7'(first_r + idx));
    wreg_wdata = {hi_byte, fb_rdata};

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        wreg_re = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        fin = 1'b1;
        case (in_kind)
          KIND_RX_BYTE: begin
            if (phase == PH_RECEIVE) begin
              if (in_gap_late || byte_index >= IW'(FRAME_BYTES)) begin
                frame_error_next = 1'b1;
              end else begin
                fb_we = 1'b1;
                fb_waddr = byte_index[AW-1:0];
                fb_wdata = in_rx_byte;
                byte_index_next = byte_index + IW'(1);
              end
            end else begin
              fb_we = 1'b1;
              fb_waddr = '0;
              fb_wdata = in_rx_byte;
              byte_index_next = IW'(1);
              frame_error_next = 1'b0;
              phase_next = PH_RECEIVE;
            end
          end
          KIND_SILENCE: begin
            if (phase == PH_RECEIVE) begin
              if (frame_error || byte_index < IW'(MIN_FRAME)) begin
                phase_next = PH_IDLE;
              end else begin
                fin = 1'b0;
                phase_next = PH_PARSE;
                len_next = byte_index;
                cnt_next = '0;
                pass2_next = 1'b0;
                crc_clear = 1'b1;
                state_next = S_CRC;
              end
            end
          end
          KIND_TX_READY: begin
            if (phase == PH_SEND) begin
              if (byte_index <= response_last && byte_index < IW'(FRAME_BYTES)) begin
                fin_tx = 1'b1;
                fin_txb = fb_rdata;
                byte_index_next = byte_index + IW'(1);
              end else begin
                phase_next = PH_SENT;
              end
            end
          end
          KIND_TX_DONE: begin
            if (phase == PH_SENT) begin
              phase_next = PH_IDLE;
            end
          end
          KIND_HOST_WRITE: begin
            rreg_we = host_in_range;
          end
          KIND_HOST_READ: begin
            fin_hread = host_in_range ? wreg_rdata : 16'h0000;
          end
          default: ;
        endcase
      end
      S_CRC: begin
        crc_feed = rd_v;
        if (cnt != len) begin
          fb_raddr = cnt[AW-1:0];
          rd_v_next = 1'b1;
          rd_pos_next = cnt;
          cnt_next = cnt + IW'(1);
        end else if (!rd_v) begin
          state_next = pass2 ? S_TAIL1 : S_CHECK;
        end
      end
      S_CHECK: begin
        if (crc != 16'h0000 ||
            (hdr[0] != slave_address && hdr[0] != BROADCAST_ADDRESS)) begin
          phase_next = PH_IDLE;
          fin = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next = '0;
          qty_r_next = qty16[6:0];
          first_r_next = first16[6:0];
          state_next = S_EXC1;
          if (hdr[1] == FC_READ_HOLDING) begin
            if (len != IW'(READ_REQ_LEN)) begin
              excode_next = EXC_ILLEGAL_VALUE;
            end else if (range_bad) begin
              excode_next = EXC_ILLEGAL_ADDRESS;
            end else if ((18'(READ_RSP_OVERHEAD) + {1'b0, qty16, 1'b0}) >
                         18'(FRAME_BYTES)) begin
              excode_next = EXC_ILLEGAL_VALUE;
            end else begin
              wptr_next = IW'(SHORT_RSP_LEN);
              state_next = S_R3_HDR;
            end
          end else if (hdr[1] == FC_WRITE_MULTIPLE) begin
            if (len <= IW'(WRITE_MIN_LEN)) begin
              excode_next = EXC_ILLEGAL_VALUE;
            end else if (range_bad) begin
              excode_next = EXC_ILLEGAL_ADDRESS;
            end else if (17'(hdr[6]) != {qty16, 1'b0} ||
                         10'(len) != (10'(hdr[6]) + 10'(WRITE_HDR_LEN))) begin
              excode_next = EXC_ILLEGAL_VALUE;
            end else begin
              state_next = S_W_LOOP;
            end
          end else begin
            excode_next = EXC_ILLEGAL_FUNCTION;
          end
        end
      end
      S_EXC1: begin
        fb_we = 1'b1;
        fb_waddr = AW'(FC_POS);
        fb_wdata = hdr[1] | EXC_FLAG;
        state_next = S_EXC2;
      end
      S_EXC2: begin
        fb_we = 1'b1;
        fb_waddr = AW'(EXC_POS);
        fb_wdata = excode;
        len_next = IW'(SHORT_RSP_LEN);
        cnt_next = '0;
        pass2_next = 1'b1;
        crc_clear = 1'b1;
        state_next = S_CRC;
      end
      S_R3_HDR: begin
        fb_we = 1'b1;
        fb_waddr = AW'(EXC_POS);
        fb_wdata = {qty_r, 1'b0};
        state_next = S_R3_LOOP;
      end
      S_R3_LOOP: begin
        if (idx == qty_r) begin
          len_next = wptr;
          cnt_next = '0;
          pass2_next = 1'b1;
          crc_clear = 1'b1;
          state_next = S_CRC;
        end else begin
          rreg_re = 1'b1;
          state_next = S_R3_WH;
        end
      end
      S_R3_WH: begin
        fb_we = 1'b1;
        fb_waddr = wptr[AW-1:0];
        fb_wdata = rreg_rdata[15:8];
        state_next = S_R3_WL;
      end
      S_R3_WL: begin
        fb_we = 1'b1;
        fb_waddr = AW'(wptr + IW'(1));
        fb_wdata = rreg_rdata[7:0];
        wptr_next = wptr + IW'(2);
        idx_next = idx + 7'd1;
        state_next = S_R3_LOOP;
      end
      S_W_LOOP: begin
        if (idx == qty_r) begin
          len_next = IW'(WRITE_RSP_LEN);
          cnt_next = '0;
          pass2_next = 1'b1;
          crc_clear = 1'b1;
          state_next = S_CRC;
        end else begin
          fb_raddr = AW'(10'(WRITE_DATA_OFS) + {2'b00, idx, 1'b0});
          state_next = S_W_HI;
        end
      end
      S_W_HI: begin
        fb_raddr = AW'(10'(WRITE_DATA_OFS + 1) + {2'b00, idx, 1'b0});
        hi_byte_next = fb_rdata;
        state_next = S_W_LO;
      end
      S_W_LO: begin
        wreg_we = 1'b1;
        idx_next = idx + 7'd1;
        state_next = S_W_LOOP;
      end
      S_TAIL1: begin
        fb_we = 1'b1;
        fb_waddr = len[AW-1:0];
        fb_wdata = crc[7:0];
        state_next = S_TAIL2;
      end
      S_TAIL2: begin
        fb_we = 1'b1;
        fb_waddr = AW'(len + IW'(1));
        fb_wdata = crc[15:8];
        response_last_next = len + IW'(1);
        fin = 1'b1;
        fin_done = 1'b1;
        state_next = S_IDLE;
        if (hdr[0] == BROADCAST_ADDRESS) begin
          phase_next = PH_IDLE;
        end else begin
          fin_tx = 1'b1;
          fin_txb = hdr[0];
          byte_index_next = IW'(1);
          phase_next = PH_SEND;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/mrs_crc.sv
// Shared CRC-16 accumulator that folds in one byte per cycle while feed is high.
module mrs_crc
  import mrs_pkg::*;
(
  input  logic        clk,
  input  logic        clear,
  input  logic        feed,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  logic [15:0] crc_next;

  always_comb begin
    crc_next = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      crc_next = crc_next[0] ? ((crc_next >> 1) ^ CRC_POLY) : (crc_next >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      crc <= CRC_INIT;
    end else if (feed) begin
      crc <= crc_next;
    end
  end

endmodule

// File: sv/mrs_regfile.sv
// Register file with per-entry valid bits that read as zero after reset.
module mrs_regfile #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AWID = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  logic [AWID-1:0] waddr,
  input  logic [15:0]     wdata,
  input  logic            re,
  input  logic [AWID-1:0] raddr,
  output logic [15:0]     rdata
);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : 16'h0000;
    end
  end

endmodule

// File: sv/mrs_checker.sv
// Port-level checker for the Modbus RTU slave engine and its bind.
module mrs_checker
  import mrs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic       tx_valid,
  input logic       drive_transmit,
  input logic       request_done,
  input logic [2:0] link_state
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an input transfer");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_tx_while_driving: assert property (@(posedge clk) disable iff (rst)
    result_valid && tx_valid |-> drive_transmit && link_state == PH_SEND)
    else $error("byte offered while not in send phase");

  a_driver_matches_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> drive_transmit == (link_state == PH_SEND || link_state == PH_SENT))
    else $error("driver direction disagrees with link phase");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && request_done |-> link_state == PH_IDLE || link_state == PH_SEND)
    else $error("request accepted with an unexpected link phase");

endmodule

bind modbus_rtu_slave_engine_top mrs_checker u_mrs_checker (.*);

// File: dv/modbus_rtu_slave_engine_checker.sv
// Checker for the Modbus RTU slave engine: predicts each result and compares it.
module modbus_rtu_slave_engine_checker
  import mrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [2:0]            kind,
  input  logic [7:0]            rx_byte,
  input  logic                  gap_late,
  input  logic [5:0]            host_index,
  input  logic [15:0]           host_value,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  result_valid,
  input  logic                  tx_valid,
  input  logic [7:0]            tx_byte,
  input  logic                  drive_transmit,
  input  logic                  request_done,
  input  logic [15:0]           host_read_data,
  input  logic [2:0]            link_state,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        drive_transmit;
    logic        request_done;
    logic [15:0] host_read_data;
    logic [2:0]  link_state;
  } link_result_t;

  logic [7:0]   frame_mem [FRAME_BYTES_DEF];
  logic [15:0]  host_regs [REG_DEPTH_DEF];
  logic [15:0]  master_regs [REG_DEPTH_DEF];
  int unsigned  byte_pos;
  int unsigned  rsp_last;
  phase_t       link_phase;
  bit           frame_bad;
  logic [7:0]   own_addr;
  logic [6:0]   reg_count;
  link_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [15:0] frame_crc(int unsigned n);
    logic [15:0] c;
    c = CRC_INIT;
    for (int unsigned i = 0; i < n && i < FRAME_BYTES_DEF; i++) begin
      c ^= {8'd0, frame_mem[i]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic void serve_frame(output logic txv, output logic [7:0] txb,
                                      output logic done);
    int unsigned n, cnt, first, qty, len, nbytes;
    logic [7:0]  fc, exc, addr;
    logic [15:0] c;
    txv = 1'b0;
    txb = 8'd0;
    done = 1'b0;
    exc = 8'd0;
    len = 0;
    n = byte_pos;
    link_phase = PH_IDLE;
    if (frame_bad || n < MIN_FRAME || n > FRAME_BYTES_DEF) return;
    if (frame_crc(n) != 16'd0) return;
    addr = frame_mem[0];
    if (addr != own_addr && addr != BROADCAST_ADDRESS) return;
    done = 1'b1;
    cnt = (reg_count > REG_DEPTH_DEF) ? REG_DEPTH_DEF : reg_count;
    fc = frame_mem[FC_POS];
    if (fc == FC_READ_HOLDING || fc == FC_WRITE_MULTIPLE) begin
      if ((fc == FC_READ_HOLDING) ? (n != READ_REQ_LEN) : (n <= WRITE_MIN_LEN)) begin
        exc = EXC_ILLEGAL_VALUE;
      end else begin
        first = {frame_mem[2], frame_mem[3]};
        qty = {frame_mem[4], frame_mem[5]};
        if (first >= cnt || first + qty > cnt) begin
          exc = EXC_ILLEGAL_ADDRESS;
        end else if (fc == FC_READ_HOLDING) begin
          if (READ_RSP_OVERHEAD + 2 * qty > FRAME_BYTES_DEF) begin
            exc = EXC_ILLEGAL_VALUE;
          end else begin
            frame_mem[EXC_POS] = 8'(2 * qty);
            len = SHORT_RSP_LEN;
            for (int unsigned i = 0; i < qty; i++) begin
              frame_mem[len] = host_regs[first + i][15:8];
              frame_mem[len + 1] = host_regs[first + i][7:0];
              len += 2;
            end
          end
        end else begin
          nbytes = frame_mem[6];
          if (nbytes != 2 * qty || n != WRITE_HDR_LEN + nbytes) begin
            exc = EXC_ILLEGAL_VALUE;
          end else begin
            for (int unsigned i = 0; i < qty; i++) begin
              master_regs[first + i] = {frame_mem[WRITE_DATA_OFS + 2 * i],
                                        frame_mem[WRITE_DATA_OFS + 2 * i + 1]};
            end
            len = WRITE_RSP_LEN;
          end
        end
      end
    end else begin
      exc = EXC_ILLEGAL_FUNCTION;
    end
    if (exc != 8'd0) begin
      frame_mem[FC_POS] = frame_mem[FC_POS] | EXC_FLAG;
      frame_mem[EXC_POS] = exc;
      len = SHORT_RSP_LEN;
    end
    c = frame_crc(len);
    frame_mem[len] = c[7:0];
    frame_mem[len + 1] = c[15:8];
    rsp_last = len + 1;
    if (addr == BROADCAST_ADDRESS) return;
    txb = frame_mem[0];
    byte_pos = 1;
    link_phase = PH_SEND;
    txv = 1'b1;
  endfunction

  function automatic link_result_t predict_event();
    link_result_t r;
    r = '0;
    case (kind)
      KIND_RX_BYTE: begin
        if (link_phase == PH_RECEIVE) begin
          if (gap_late) frame_bad = 1'b1;
          else if (byte_pos >= FRAME_BYTES_DEF) frame_bad = 1'b1;
          else begin
            frame_mem[byte_pos] = rx_byte;
            byte_pos++;
          end
        end else begin
          frame_mem[0] = rx_byte;
          byte_pos = 1;
          frame_bad = 1'b0;
          link_phase = PH_RECEIVE;
        end
      end
      KIND_SILENCE: begin
        if (link_phase == PH_RECEIVE) serve_frame(r.tx_valid, r.tx_byte, r.request_done);
      end
      KIND_TX_READY: begin
        if (link_phase == PH_SEND) begin
          if (byte_pos <= rsp_last && byte_pos < FRAME_BYTES_DEF) begin
            r.tx_valid = 1'b1;
            r.tx_byte = frame_mem[byte_pos];
            byte_pos = (byte_pos + 1) & 9'h1FF;
          end else begin
            link_phase = PH_SENT;
          end
        end
      end
      KIND_TX_DONE: begin
        if (link_phase == PH_SENT) link_phase = PH_IDLE;
      end
      KIND_HOST_WRITE: host_regs[host_index] = host_value;
      KIND_HOST_READ: r.host_read_data = master_regs[host_index];
      default: ;
    endcase
    r.drive_transmit = (link_phase == PH_SEND || link_phase == PH_SENT);
    r.link_state = link_phase;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    link_result_t e;
    if (rst) begin
      for (int i = 0; i < REG_DEPTH_DEF; i++) begin
        host_regs[i] = 16'd0;
        master_regs[i] = 16'd0;
      end
      byte_pos = 0;
      rsp_last = 0;
      link_phase = PH_IDLE;
      frame_bad = 1'b0;
      own_addr = SLAVE_ADDRESS_RST;
      reg_count = REGISTER_COUNT_RST;
      expected_results.delete();
    end else begin
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("tx_valid", e.tx_valid, tx_valid);
          check_field("tx_byte", e.tx_byte, tx_byte);
          check_field("drive_transmit", e.drive_transmit, drive_transmit);
          check_field("request_done", e.request_done, request_done);
          check_field("host_read_data", e.host_read_data, host_read_data);
          check_field("link_state", e.link_state, link_state);
        end
      end
      if (cfg_write) begin
        if (cfg_index == CFG_SLAVE_ADDRESS) own_addr = cfg_data;
        else if (cfg_index == CFG_REGISTER_COUNT) reg_count = cfg_data[6:0];
      end
      if (start && !busy) expected_results.push_back(predict_event());
    end
  end

  initial errors = 0;

endmodule

// File: dv/modbus_rtu_slave_engine_top_tb.sv
// Testbench top for the Modbus RTU slave engine: stimulus, watchdog and verdict.
module modbus_rtu_slave_engine_top_tb;
  import mrs_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 5000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [2:0]            kind;
  logic [7:0]            rx_byte;
  logic                  gap_late;
  logic [5:0]            host_index;
  logic [15:0]           host_value;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  result_valid;
  logic                  tx_valid;
  logic [7:0]            tx_byte;
  logic                  drive_transmit;
  logic                  request_done;
  logic [15:0]           host_read_data;
  logic [2:0]            link_state;
  int                    errors;
  int                    pending;

  logic [7:0]  req_bytes [$];
  logic [2:0]  last_state;
  logic [7:0]  cur_addr;
  int unsigned cur_count;
  int          item_count;
  bit          gaps_on;
  int          stall_cycles;

  modbus_rtu_slave_engine_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .rx_byte(rx_byte), .gap_late(gap_late), .host_index(host_index),
    .host_value(host_value), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .tx_valid(tx_valid),
    .tx_byte(tx_byte), .drive_transmit(drive_transmit), .request_done(request_done),
    .host_read_data(host_read_data), .link_state(link_state)
  );

  modbus_rtu_slave_engine_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .rx_byte(rx_byte), .gap_late(gap_late), .host_index(host_index),
    .host_value(host_value), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .tx_valid(tx_valid),
    .tx_byte(tx_byte), .drive_transmit(drive_transmit), .request_done(request_done),
    .host_read_data(host_read_data), .link_state(link_state),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_write) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("modbus_rtu_slave_engine_top_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One event transfer, then wait for its result and keep the reported link state.
  task automatic do_event(input logic [2:0] k, input logic [7:0] b, input logic late,
                          input logic [5:0] idx, input logic [15:0] val);
    if (gaps_on && $urandom_range(0, 99) < 9) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    rx_byte <= b;
    gap_late <= late;
    host_index <= idx;
    host_value <= val;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    do @(posedge clk); while (!result_valid);
    last_state = link_state;
    item_count++;
  endtask

  task automatic plain_event(input logic [2:0] k);
    do_event(k, 8'($urandom), 1'($urandom), 6'($urandom), 16'($urandom));
  endtask

  task automatic host_access(input logic [2:0] k, input logic [5:0] idx,
                             input logic [15:0] val);
    do_event(k, 8'($urandom), 1'($urandom), idx, val);
  endtask

  function automatic void seal_request();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (req_bytes[i]) begin
      c ^= {8'd0, req_bytes[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    req_bytes.push_back(c[7:0]);
    req_bytes.push_back(c[15:8]);
  endfunction

  function automatic void build_read(logic [7:0] addr, logic [15:0] first, logic [15:0] qty);
    req_bytes = {addr, FC_READ_HOLDING, first[15:8], first[7:0], qty[15:8], qty[7:0]};
    seal_request();
  endfunction

  function automatic void build_write(logic [7:0] addr, logic [15:0] first, logic [15:0] qty,
                                      logic [7:0] nbytes, int data_bytes);
    req_bytes = {addr, FC_WRITE_MULTIPLE, first[15:8], first[7:0], qty[15:8], qty[7:0],
                 nbytes};
    repeat (data_bytes) req_bytes.push_back(8'($urandom));
    seal_request();
  endfunction

  function automatic void build_other(logic [7:0] addr, int extra);
    logic [7:0] fc;
    do fc = 8'($urandom); while (fc == FC_READ_HOLDING || fc == FC_WRITE_MULTIPLE);
    req_bytes = {addr, fc};
    repeat (extra) req_bytes.push_back(8'($urandom));
    seal_request();
  endfunction

  // Sends the request, the silence, then takes the response out byte by byte.
  task automatic run_request(input int late_at, input bit may_abandon);
    int guard;
    foreach (req_bytes[i]) do_event(KIND_RX_BYTE, req_bytes[i], i == late_at,
                                    6'($urandom), 16'($urandom));
    plain_event(KIND_SILENCE);
    guard = 0;
    while (last_state == PH_SEND && guard < 300) begin
      if (may_abandon && $urandom_range(0, 99) < 3) return;
      plain_event(KIND_TX_READY);
      guard++;
    end
    if (last_state == PH_SENT && (!may_abandon || $urandom_range(0, 9) != 0)) begin
      plain_event(KIND_TX_DONE);
    end
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [6:0] cnt);
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDRESS;
    cfg_data <= addr;
    @(posedge clk);
    cfg_index <= CFG_REGISTER_COUNT;
    cfg_data <= {1'b0, cnt};
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    cur_addr = addr;
    cur_count = cnt;
  endtask

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return cur_addr;
    if (r < 92) return BROADCAST_ADDRESS;
    return 8'($urandom);
  endfunction

  task automatic random_request();
    int r, first, qty;
    r = $urandom_range(0, 99);
    first = $urandom_range(0, cur_count - 1);
    qty = $urandom_range(0, (cur_count - first < 4) ? cur_count - first : 4);
    if ($urandom_range(0, 99) < 3) qty = cur_count - first;
    if (r < 35) begin
      build_read(pick_addr(), 16'(first), 16'(qty));
      run_request(-1, 1'b1);
    end else if (r < 63) begin
      if (qty == 0) qty = 1;
      build_write(pick_addr(), 16'(first), 16'(qty), 8'(2 * qty), 2 * qty);
      run_request(-1, 1'b1);
    end else if (r < 70) begin
      build_other(pick_addr(), $urandom_range(0, 8));
      run_request(-1, 1'b1);
    end else if (r < 76) begin
      case ($urandom_range(0, 3))
        0: build_read(cur_addr, 16'($urandom), 16'($urandom));
        1: build_read(cur_addr, 16'(first), 16'(cur_count - first + 1));
        2: build_write(cur_addr, 16'(first), 16'd1, 8'($urandom_range(0, 4)),
                       $urandom_range(0, 4));
        default: build_write(cur_addr, 16'($urandom), 16'($urandom), 8'd2, 2);
      endcase
      run_request(-1, 1'b1);
    end else if (r < 82) begin
      build_read(cur_addr, 16'(first), 16'(qty));
      req_bytes[$urandom_range(0, req_bytes.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
      run_request(-1, 1'b1);
    end else if (r < 86) begin
      build_write(cur_addr, 16'(first), 16'd1, 8'd2, 2);
      run_request($urandom_range(1, req_bytes.size() - 1), 1'b1);
    end else if (r < 88) begin
      req_bytes.delete();
      repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom));
      run_request(-1, 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 6))
          0: host_access(KIND_HOST_WRITE, 6'($urandom), 16'($urandom));
          1: host_access(KIND_HOST_READ, 6'($urandom), 16'($urandom));
          2: plain_event(KIND_TX_READY);
          3: plain_event(KIND_TX_DONE);
          4: plain_event(KIND_SILENCE);
          5: plain_event(KIND_SPARE_A);
          default: plain_event(KIND_SPARE_B);
        endcase
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_RX_BYTE;
    rx_byte <= 8'd0;
    gap_late <= 1'b0;
    host_index <= 6'd0;
    host_value <= 16'd0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_SLAVE_ADDRESS;
    cfg_data <= 8'd0;
    item_count = 0;
    gaps_on = 1'b1;
    cur_addr = SLAVE_ADDRESS_RST;
    cur_count = REGISTER_COUNT_RST;
    last_state = PH_IDLE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    host_access(KIND_HOST_WRITE, 6'd0, 16'hFFFF);
    host_access(KIND_HOST_WRITE, 6'd63, 16'h8001);
    host_access(KIND_HOST_READ, 6'd63, 16'd0);
    plain_event(KIND_SILENCE);
    plain_event(KIND_TX_READY);
    plain_event(KIND_TX_DONE);
    plain_event(KIND_SPARE_A);
    plain_event(KIND_SPARE_B);
    build_write(cur_addr, 16'd62, 16'd2, 8'd4, 4);
    run_request(-1, 1'b0);
    host_access(KIND_HOST_READ, 6'd63, 16'd0);
    build_read(cur_addr, 16'd63, 16'd1);
    run_request(-1, 1'b0);
    build_read(cur_addr, 16'd0, 16'd0);
    run_request(-1, 1'b0);
    build_other(cur_addr, 2);
    run_request(-1, 1'b0);
    build_read(cur_addr, 16'd63, 16'd2);
    run_request(-1, 1'b0);
    build_write(cur_addr, 16'd0, 16'd1, 8'd2, 1);
    run_request(-1, 1'b0);
    build_write(BROADCAST_ADDRESS, 16'd5, 16'd1, 8'd2, 2);
    run_request(-1, 1'b0);
    build_read(cur_addr, 16'd0, 16'd1);
    run_request(3, 1'b0);
    req_bytes.delete();
    repeat (FRAME_BYTES_DEF + 2) req_bytes.push_back(8'($urandom));
    run_request(-1, 1'b0);

    set_config(8'd247, 7'd1);
    build_read(8'd247, 16'd0, 16'd1);
    run_request(-1, 1'b0);
    set_config(8'd1, 7'd64);
    build_read(8'd1, 16'd0, 16'd64);
    run_request(-1, 1'b0);

    while (item_count < 950) begin
      gaps_on = !(item_count > 400 && item_count < 600);
      if ($urandom_range(0, 99) < 2) begin
        case ($urandom_range(0, 2))
          0: set_config(8'd247, 7'($urandom_range(1, 64)));
          1: set_config(8'($urandom_range(1, 247)), 7'd1);
          default: set_config(8'($urandom_range(1, 247)), 7'($urandom_range(1, 64)));
        endcase
      end
      random_request();
    end

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("modbus_rtu_slave_engine_top_tb: PASS");
    end else begin
      $display("modbus_rtu_slave_engine_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mrs_pkg.sv
sv/mrs_crc.sv
sv/mrs_regfile.sv
sv/modbus_rtu_slave_engine_top.sv
sv/mrs_checker.sv
dv/modbus_rtu_slave_engine_checker.sv
dv/modbus_rtu_slave_engine_top_tb.sv
